// ===== rtl/zssf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the zlib stored-stream framer: constants, input codes and the
// job descriptor passed from the front end to the back end. No dependencies.
package zssf_pkg;

  localparam int unsigned LENGTH_BITS = 32;
  localparam int unsigned BLOCK_MAX   = 65535;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [7:0]  ZLIB_CMF  = 8'h78;
  localparam logic [7:0]  ZLIB_FLG  = 8'h01;

  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_DATA  = 2'd1,
    JOB_DROP  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [7:0]  data;
    logic        has_blk;
    logic        blk_final;
    logic [15:0] blk_len;
    logic        has_cks;
    logic [31:0] adler;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } queue_stat_t;

  // Length field of a block header for the bytes still to come.
  function automatic logic [15:0] blk_len_of(input logic [LENGTH_BITS-1:0] rem);
    logic [LENGTH_BITS-1:0] lim;
    lim = LENGTH_BITS'(BLOCK_MAX);
    blk_len_of = (rem < lim) ? rem[15:0] : 16'(BLOCK_MAX);
  endfunction

  function automatic logic blk_final_of(input logic [LENGTH_BITS-1:0] rem);
    blk_final_of = (rem <= LENGTH_BITS'(BLOCK_MAX));
  endfunction

endpackage

// ===== rtl/zssf_front.sv =====
`timescale 1ns / 1ps
// Front end of the framer: accepts input items, keeps the stream state and the
// Adler-32 sums, and turns each item into a job descriptor. Uses zssf_pkg.
module zssf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [zssf_pkg::LENGTH_BITS-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic [7:0]                          data_byte_i,
  input  zssf_pkg::queue_stat_t               stat_i,
  output logic                                push_o,
  output zssf_pkg::job_t                      job_o
);
  import zssf_pkg::*;

  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d, rem_dec;
  logic [15:0]            lo_q, lo_d, hi_q, hi_d, lo_n, hi_n;
  logic [15:0]            fill_q, fill_d, fill_inc;
  logic                   open_q, open_d;
  logic [16:0]            s_lo, s_hi;
  logic                   accept;

  assign accept     = in_valid_i && !stat_i.full;
  assign in_ready_o = !stat_i.full;
  assign push_o     = accept;

  // Adler-32 update: two add-and-reduce steps on 17 bits.
  always_comb begin
    s_lo = {1'b0, lo_q} + {9'b0, data_byte_i};
    lo_n = (s_lo >= ADLER_MOD) ? 16'(s_lo - ADLER_MOD) : s_lo[15:0];
    s_hi = {1'b0, hi_q} + {1'b0, lo_n};
    hi_n = (s_hi >= ADLER_MOD) ? 16'(s_hi - ADLER_MOD) : s_hi[15:0];
  end

  assign rem_dec  = rem_q - LENGTH_BITS'(1);
  assign fill_inc = fill_q + 16'd1;

  always_comb begin
    len_d  = cfg_we_i ? cfg_data_i : len_q;
    rem_d  = rem_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    fill_d = fill_q;
    open_d = open_q;
    job_o  = '0;
    job_o.kind = JOB_DROP;
    if (accept) begin
      if (op_i == OP_START) begin
        rem_d           = len_q;
        lo_d            = 16'd1;
        hi_d            = 16'd0;
        fill_d          = 16'd0;
        open_d          = (len_q != '0);
        job_o.kind      = JOB_START;
        job_o.has_blk   = 1'b1;
        job_o.blk_final = blk_final_of(len_q);
        job_o.blk_len   = blk_len_of(len_q);
        job_o.has_cks   = (len_q == '0);
        job_o.adler     = 32'h0000_0001;
      end else if (!open_q) begin
        job_o.kind = JOB_DROP;
      end else begin
        rem_d       = rem_dec;
        lo_d        = lo_n;
        hi_d        = hi_n;
        fill_d      = fill_inc;
        job_o.kind  = JOB_DATA;
        job_o.data  = data_byte_i;
        job_o.adler = {hi_n, lo_n};
        if (rem_dec == '0) begin
          job_o.has_cks = 1'b1;
          open_d        = 1'b0;
        end else if (fill_inc == 16'(BLOCK_MAX)) begin
          fill_d          = 16'd0;
          job_o.has_blk   = 1'b1;
          job_o.blk_final = blk_final_of(rem_dec);
          job_o.blk_len   = blk_len_of(rem_dec);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      rem_q  <= '0;
      lo_q   <= 16'd1;
      hi_q   <= 16'd0;
      fill_q <= 16'd0;
      open_q <= 1'b0;
    end else begin
      len_q  <= len_d;
      rem_q  <= rem_d;
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      fill_q <= fill_d;
      open_q <= open_d;
    end
  end

endmodule

// ===== rtl/zssf_queue.sv =====
`timescale 1ns / 1ps
// Short job queue between front and back end of the framer.
// Uses zssf_pkg for the job type and depth.
module zssf_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  zssf_pkg::job_t         job_i,
  input  logic                   pop_i,
  output zssf_pkg::queue_stat_t  stat_o,
  output zssf_pkg::job_t         job_o
);
  import zssf_pkg::*;

  job_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wp_q, rp_q;
  logic [QUEUE_AW:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign stat_o.valid = (cnt_q != '0);
  assign job_o        = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + QUEUE_AW'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + QUEUE_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QUEUE_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/zssf_back.sv =====
`timescale 1ns / 1ps
// Back end of the framer: walks each job through its output byte positions
// and holds the result in an output register. Uses zssf_pkg.
module zssf_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  zssf_pkg::queue_stat_t  stat_i,
  input  zssf_pkg::job_t         job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   last_of_run_o,
  output logic                   stream_done_o,
  output logic                   error_o
);
  import zssf_pkg::*;

  // Byte positions of one job, in stream order.
  localparam logic [3:0] P_ZH0 = 4'd0;
  localparam logic [3:0] P_ZH1 = 4'd1;
  localparam logic [3:0] P_PAY = 4'd2;
  localparam logic [3:0] P_BH0 = 4'd3;
  localparam logic [3:0] P_BH1 = 4'd4;
  localparam logic [3:0] P_BH2 = 4'd5;
  localparam logic [3:0] P_BH3 = 4'd6;
  localparam logic [3:0] P_BH4 = 4'd7;
  localparam logic [3:0] P_CK0 = 4'd8;
  localparam logic [3:0] P_CK1 = 4'd9;
  localparam logic [3:0] P_CK2 = 4'd10;
  localparam logic [3:0] P_CK3 = 4'd11;

  logic [3:0] step_q, pos, nxt;
  logic       busy_q;
  logic       advance, last, done, err;
  logic [7:0] byte_v;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       last_q, done_q, err_q;

  assign pos     = busy_q ? step_q : ((job_i.kind == JOB_START) ? P_ZH0 : P_PAY);
  assign advance = stat_i.valid && (!out_valid_q || out_ready_i);
  assign pop_o   = advance && last;

  always_comb begin
    byte_v = 8'h00;
    nxt    = P_ZH0;
    last   = 1'b0;
    done   = 1'b0;
    err    = 1'b0;
    unique case (pos)
      P_ZH0: begin
        byte_v = ZLIB_CMF;
        nxt    = P_ZH1;
      end
      P_ZH1: begin
        byte_v = ZLIB_FLG;
        nxt    = P_BH0;
      end
      P_PAY: begin
        if (job_i.kind == JOB_DROP) begin
          err  = 1'b1;
          last = 1'b1;
        end else begin
          byte_v = job_i.data;
          if (job_i.has_blk) begin
            nxt = P_BH0;
          end else if (job_i.has_cks) begin
            nxt = P_CK0;
          end else begin
            last = 1'b1;
          end
        end
      end
      P_BH0: begin
        byte_v = {7'b0, job_i.blk_final};
        nxt    = P_BH1;
      end
      P_BH1: begin
        byte_v = job_i.blk_len[7:0];
        nxt    = P_BH2;
      end
      P_BH2: begin
        byte_v = job_i.blk_len[15:8];
        nxt    = P_BH3;
      end
      P_BH3: begin
        byte_v = ~job_i.blk_len[7:0];
        nxt    = P_BH4;
      end
      P_BH4: begin
        byte_v = ~job_i.blk_len[15:8];
        if (job_i.has_cks) begin
          nxt = P_CK0;
        end else begin
          last = 1'b1;
        end
      end
      P_CK0: begin
        byte_v = job_i.adler[31:24];
        nxt    = P_CK1;
      end
      P_CK1: begin
        byte_v = job_i.adler[23:16];
        nxt    = P_CK2;
      end
      P_CK2: begin
        byte_v = job_i.adler[15:8];
        nxt    = P_CK3;
      end
      P_CK3: begin
        byte_v = job_i.adler[7:0];
        last   = 1'b1;
        done   = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= P_ZH0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        busy_q <= !last;
        step_q <= nxt;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= byte_v;
      last_q     <= last;
      done_q     <= done;
      err_q      <= err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;
  assign stream_done_o = done_q;
  assign error_o       = err_q;

endmodule

// ===== rtl/zlib_stored_stream_framer_unit.sv =====
`timescale 1ns / 1ps
// zlib stored-block stream framer, top level. Uses zssf_pkg, zssf_front,
// zssf_queue and zssf_back. The first result byte of an item passes through
// the queue entry and then the back end's output register. Throughput: one
// result byte per cycle when a job is queued and out_ready_i allows, set by
// the back end's single output register; an item has 1, 5, 6, 7 or 11 results.
// Reset (rst_ni low, asynchronous) closes any stream, clears the queue and length.
module zlib_stored_stream_framer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [zssf_pkg::LENGTH_BITS-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [7:0]                        data_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        out_byte_o,
  output logic                              last_of_run_o,
  output logic                              stream_done_o,
  output logic                              error_o
);
  import zssf_pkg::*;

  // The front end takes one input transfer per cycle whenever the queue has
  // room. It updates the running length, block fill and Adler-32 sums at
  // once, so the back end never needs to look back at stream state.
  queue_stat_t stat;
  job_t        push_job, head_job;
  logic        push, pop;

  zssf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .stat_i      (stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  // The queue absorbs the bursts of header and trailer bytes, so payload
  // transfers keep flowing while a block header or checksum drains.
  zssf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .stat_o (stat),
    .job_o  (head_job)
  );

  // The back end expands the head job into result bytes, one per output
  // transfer, and retires the job with its last byte.
  zssf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stat_i        (stat),
    .job_i         (head_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o),
    .error_o       (error_o)
  );

  // The front end never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !stat.full)
    else $error("job pushed into a full queue");

  // The back end only retires a job that is present.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> stat.valid)
    else $error("job popped from an empty queue");

  // The checksum end always closes the run of its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stream_done_o) |-> (last_of_run_o && !error_o))
    else $error("stream end not marked as end of run");

  // A dropped byte is answered by a single zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_o) |-> (last_of_run_o && (out_byte_o == 8'h00)))
    else $error("malformed error result");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for zlib_stored_stream_framer_unit. Directed and random
// streams are checked against a built-in predictor of the framed bytes.
// Depends on zssf_pkg and the framer RTL only.
module testbench;
  import zssf_pkg::*;

  // Number of random input items, the longest idle draw on either side, and a
  // hang guard. The guard is several times the slowest correct run: every
  // item taking eleven result transfers with the longest stall on each one,
  // plus the longest idle gap before it.
  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned MAX_GAP      = 17;
  localparam int unsigned CYCLE_LIMIT  = 500_000;

  // One byte of the framed stream, as the predictor expects it.
  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       done;
    logic       err;
  } framed_byte_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [LENGTH_BITS-1:0] cfg_data_i    = '0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_ready_o;
  logic                   op_i          = OP_START;
  logic [7:0]             data_byte_i   = 8'h00;
  logic                   out_valid_o;
  logic                   out_ready_i   = 1'b0;
  logic [7:0]             out_byte_o;
  logic                   last_of_run_o;
  logic                   stream_done_o;
  logic                   error_o;

  // Predictor state. These start at the values the framer holds after reset:
  // no stream open, a zero length register and an Adler-32 of one.
  logic [LENGTH_BITS-1:0] length_reg   = '0;
  logic [LENGTH_BITS-1:0] frame_total  = '0;
  logic [LENGTH_BITS-1:0] bytes_framed = '0;
  logic [15:0]            adler_lo     = 16'd1;
  logic [15:0]            adler_hi     = 16'd0;
  int unsigned            block_bytes  = 0;
  bit                     stream_live  = 1'b0;

  // Framed bytes still owed by the framer, oldest first.
  framed_byte_t framed_q[$];
  framed_byte_t want_byte;

  // When pacing is off, neither side idles, which gives back-to-back stretches.
  bit          pace_on        = 1'b1;
  bit          result_taken   = 1'b0;
  int unsigned stall_left     = 0;
  int unsigned items_sent     = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  zlib_stored_stream_framer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .stream_done_o (stream_done_o),
    .error_o       (error_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor of the framed stream
  // ---------------------------------------------------------------------------

  function automatic void push_framed(input logic [7:0] value, input logic done,
                                      input logic err);
    framed_byte_t fb;
    fb.value = value;
    fb.last  = 1'b0;
    fb.done  = done;
    fb.err   = err;
    framed_q.push_back(fb);
  endfunction

  // A stored-block header covers the bytes still to come: it is final when
  // they fit in one block, and LEN is followed by its ones' complement.
  function automatic void push_block_header();
    logic [LENGTH_BITS-1:0] remain;
    logic                   last_block;
    logic [15:0]            blen;
    remain     = frame_total - bytes_framed;
    last_block = (remain <= BLOCK_MAX);
    blen       = last_block ? remain[15:0] : 16'(BLOCK_MAX);
    push_framed({7'd0, last_block}, 1'b0, 1'b0);
    push_framed(blen[7:0], 1'b0, 1'b0);
    push_framed(blen[15:8], 1'b0, 1'b0);
    push_framed(~blen[7:0], 1'b0, 1'b0);
    push_framed(~blen[15:8], 1'b0, 1'b0);
  endfunction

  // The Adler-32 trailer goes out big-endian and closes the stream.
  function automatic void push_adler();
    push_framed(adler_hi[15:8], 1'b0, 1'b0);
    push_framed(adler_hi[7:0], 1'b0, 1'b0);
    push_framed(adler_lo[15:8], 1'b0, 1'b0);
    push_framed(adler_lo[7:0], 1'b1, 1'b0);
    stream_live = 1'b0;
  endfunction

  // Works out every framed byte that one accepted input item causes.
  function automatic void frame_input(input logic op, input logic [7:0] data);
    logic [16:0] acc;
    if (op == OP_START) begin
      // A start abandons any open stream and latches the length register.
      adler_lo     = 16'd1;
      adler_hi     = 16'd0;
      frame_total  = length_reg;
      bytes_framed = '0;
      block_bytes  = 0;
      stream_live  = 1'b1;
      push_framed(ZLIB_CMF, 1'b0, 1'b0);
      push_framed(ZLIB_FLG, 1'b0, 1'b0);
      push_block_header();
      if (frame_total == '0) begin
        push_adler();
      end
    end else if (!stream_live) begin
      // No stream open: the byte is dropped and answered by an error.
      push_framed(8'h00, 1'b0, 1'b1);
    end else begin
      push_framed(data, 1'b0, 1'b0);
      // Both halves stay below the modulus, so one subtraction suffices.
      acc = {1'b0, adler_lo} + data;
      if (acc >= ADLER_MOD) begin
        acc = acc - ADLER_MOD;
      end
      adler_lo = acc[15:0];
      acc = {1'b0, adler_hi} + adler_lo;
      if (acc >= ADLER_MOD) begin
        acc = acc - ADLER_MOD;
      end
      adler_hi = acc[15:0];
      bytes_framed++;
      block_bytes++;
      if (bytes_framed >= frame_total) begin
        push_adler();
      end else if (block_bytes >= BLOCK_MAX) begin
        block_bytes = 0;
        push_block_header();
      end
    end
    framed_q[framed_q.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Sends one item. Inputs change on the falling edge; the transfer is seen on
  // the rising edge where valid and ready are both high. Valid stays high into
  // the next call unless that call draws an idle gap.
  task automatic send_item(input logic op, input logic [7:0] data);
    int unsigned gap;
    gap = pace_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    frame_input(op, data);
    items_sent++;
  endtask

  // Stops sending and waits until every predicted byte has been transferred,
  // then lets the single output register settle before returning.
  task automatic wait_framer_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (framed_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // The length register is only written while the framer is idle. A write in
  // the middle of a stream leaves that stream's latched total alone.
  task automatic write_length(input logic [LENGTH_BITS-1:0] value);
    wait_framer_idle();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    length_reg = value;
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < 50) begin
      $display("mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
               results_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  // Every result transfer is compared field by field with the oldest byte the
  // predictor still owes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (framed_q.size() == 0) begin
        report_mismatch("transfer with nothing owed, out_byte", out_byte_o, 8'h00);
      end else begin
        want_byte = framed_q.pop_front();
        if (out_byte_o !== want_byte.value)
          report_mismatch("out_byte", out_byte_o, want_byte.value);
        if (last_of_run_o !== want_byte.last)
          report_mismatch("last_of_run", 8'(last_of_run_o), 8'(want_byte.last));
        if (stream_done_o !== want_byte.done)
          report_mismatch("stream_done", 8'(stream_done_o), 8'(want_byte.done));
        if (error_o !== want_byte.err)
          report_mismatch("error", 8'(error_o), 8'(want_byte.err));
      end
      result_taken = 1'b1;
    end
  end

  // After each result transfer the receiver draws a fresh stall, so stalls land
  // on header, payload and trailer bytes alike.
  always @(negedge clk_i) begin
    if (result_taken) begin
      stall_left   = pace_on ? $urandom_range(0, MAX_GAP) : 0;
      result_taken = 1'b0;
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d framed bytes still owed", framed_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset no stream is open, so any byte is an error.
  task automatic test_byte_before_start();
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
  endtask

  // The reset length is zero: header, an empty final block and the checksum
  // all come from the start, and a byte after that is an error.
  task automatic test_empty_payload();
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'hA5);
  endtask

  // One- and three-byte payloads with extreme byte values, then one byte
  // beyond the configured length.
  task automatic test_short_streams();
    write_length(1);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    write_length(3);
    send_item(OP_START, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_BYTE, 8'h55);
  endtask

  // The largest length gives a non-final first block. A length write in the
  // middle of that stream must only apply at the next start, which also
  // abandons the open stream without a trailer.
  task automatic test_restart_and_midstream_write();
    write_length('1);
    send_item(OP_START, 8'h00);
    send_item(OP_BYTE, 8'h5A);
    send_item(OP_BYTE, 8'hC3);
    write_length(2);
    send_item(OP_BYTE, 8'h11);
    send_item(OP_START, 8'hFF);
    send_item(OP_BYTE, 8'hFE);
    send_item(OP_BYTE, 8'h01);
  endtask

  // Mostly well-formed streams with random content: a length write, a start and
  // the payload. Some streams are cut short, some get a length write midway,
  // some run past their end, and a few are long ones abandoned after a handful
  // of bytes. The rest is noise with random operations.
  task automatic test_random_streams();
    int unsigned            first_item;
    int unsigned            plan;
    int unsigned            nbytes;
    int unsigned            rewrite_at;
    logic [LENGTH_BITS-1:0] len;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      pace_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 8) begin
        plan = $urandom_range(0, 9);
        if (plan == 0) begin
          len = '0;
        end else if (plan == 1) begin
          len = $urandom_range(BLOCK_MAX, 32'hFFFF_FFFF);
        end else begin
          len = $urandom_range(1, 24);
        end
        write_length(len);
        send_item(OP_START, 8'($urandom_range(0, 255)));
        nbytes = (plan == 1) ? $urandom_range(0, 8) : int'(len);
        if ($urandom_range(0, 5) == 0) begin
          nbytes = $urandom_range(0, nbytes);
        end
        rewrite_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, nbytes) : nbytes + 1;
        for (int unsigned i = 0; i < nbytes; i++) begin
          if (i == rewrite_at) begin
            write_length($urandom());
          end
          send_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 2)) send_item(OP_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    // Reset is held at the start and released on a falling edge.
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_byte_before_start();
    test_empty_payload();
    test_short_streams();
    test_restart_and_midstream_write();
    test_random_streams();

    wait_framer_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== zlib_stored_stream_framer_unit.f =====
rtl/zssf_pkg.sv
rtl/zssf_front.sv
rtl/zssf_queue.sv
rtl/zssf_back.sv
rtl/zlib_stored_stream_framer_unit.sv
test/testbench.sv
